@@ src/utf8_stream_validator_defines.svh @@
// ----------------------------------------------------------------------------
// UTF-8 stream validator assertion macros
// Shared concurrent-check wrappers, clocked on clk_i, gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_VALIDATOR_DEFINES_SVH
`define UTF8_STREAM_VALIDATOR_DEFINES_SVH

// same-cycle implication
`define U8V_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define U8V_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/u8v_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream validator package
// Byte constants, window codes and the classified-byte record.
// ----------------------------------------------------------------------------
package u8v_pkg;

  localparam int unsigned FifoDepthDef = 2;

  // window codes for the first continuation byte of a sequence
  typedef enum logic [2:0] {
    WIN_ANY   = 3'd0,  // 80-BF
    WIN_A0_BF = 3'd1,
    WIN_80_9F = 3'd2,
    WIN_90_BF = 3'd3,
    WIN_80_8F = 3'd4
  } win_e;

  localparam int unsigned NumWin = 5;

  localparam logic [7:0] ContMask = 8'hC0;
  localparam logic [7:0] ContTag  = 8'h80;
  localparam logic [7:0] Lead2Lo  = 8'hC2;
  localparam logic [7:0] Lead2Hi  = 8'hDF;
  localparam logic [7:0] ByteA0   = 8'hA0;
  localparam logic [7:0] ByteBF   = 8'hBF;
  localparam logic [7:0] Byte9F   = 8'h9F;
  localparam logic [7:0] Byte90   = 8'h90;
  localparam logic [7:0] Byte8F   = 8'h8F;
  localparam logic [7:0] LeadE0   = 8'hE0;
  localparam logic [7:0] LeadED   = 8'hED;
  localparam logic [7:0] LeadE1   = 8'hE1;
  localparam logic [7:0] LeadEF   = 8'hEF;
  localparam logic [7:0] LeadF0   = 8'hF0;
  localparam logic [7:0] LeadF1   = 8'hF1;
  localparam logic [7:0] LeadF3   = 8'hF3;
  localparam logic [7:0] LeadF4   = 8'hF4;

  // byte as seen by the back end: both readings precomputed
  typedef struct packed {
    logic              last;
    logic [1:0]        lead_due;
    win_e              lead_win;
    logic              lead_bad;
    logic [NumWin-1:0] cont_ok;
  } class_t;

endpackage

@@ src/u8v_if.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream validator channels
// Valid/ready byte input channel and verdict output channel.
// ----------------------------------------------------------------------------
interface u8v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, data_byte, end_of_string, input ready);
  modport sink   (input valid, data_byte, end_of_string, output ready);
endinterface

interface u8v_out_if;
  logic valid;
  logic ready;
  logic fault_seen;
  logic verdict_ready;
  logic string_valid;

  modport source (output valid, fault_seen, verdict_ready, string_valid, input ready);
  modport sink   (input valid, fault_seen, verdict_ready, string_valid, output ready);
endinterface

@@ src/u8v_front.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream validator front end
// Accepts bytes, classifies each as lead and as continuation, registers it.
// ----------------------------------------------------------------------------
module u8v_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      data_byte_i,
  input  logic            end_of_string_i,
  output logic            cls_valid_o,
  input  logic            cls_ready_i,
  output u8v_pkg::class_t cls_o
);

  logic            vld_q, vld_d;
  u8v_pkg::class_t cls_q;
  u8v_pkg::class_t cls_c;
  logic            take;

  always_comb begin
    cls_c          = '0;
    cls_c.last     = end_of_string_i;
    cls_c.lead_win = u8v_pkg::WIN_ANY;

    cls_c.cont_ok[u8v_pkg::WIN_ANY] =
      (data_byte_i & u8v_pkg::ContMask) == u8v_pkg::ContTag;
    cls_c.cont_ok[u8v_pkg::WIN_A0_BF] =
      data_byte_i inside {[u8v_pkg::ByteA0 : u8v_pkg::ByteBF]};
    cls_c.cont_ok[u8v_pkg::WIN_80_9F] =
      data_byte_i inside {[u8v_pkg::ContTag : u8v_pkg::Byte9F]};
    cls_c.cont_ok[u8v_pkg::WIN_90_BF] =
      data_byte_i inside {[u8v_pkg::Byte90 : u8v_pkg::ByteBF]};
    cls_c.cont_ok[u8v_pkg::WIN_80_8F] =
      data_byte_i inside {[u8v_pkg::ContTag : u8v_pkg::Byte8F]};

    if (!data_byte_i[7]) begin
      cls_c.lead_due = 2'd0;
    end else if (data_byte_i inside {[u8v_pkg::Lead2Lo : u8v_pkg::Lead2Hi]}) begin
      cls_c.lead_due = 2'd1;
    end else if (data_byte_i == u8v_pkg::LeadE0) begin
      cls_c.lead_due = 2'd2;
      cls_c.lead_win = u8v_pkg::WIN_A0_BF;
    end else if (data_byte_i == u8v_pkg::LeadED) begin
      // surrogates excluded
      cls_c.lead_due = 2'd2;
      cls_c.lead_win = u8v_pkg::WIN_80_9F;
    end else if (data_byte_i inside {[u8v_pkg::LeadE1 : u8v_pkg::LeadEF]}) begin
      cls_c.lead_due = 2'd2;
    end else if (data_byte_i == u8v_pkg::LeadF0) begin
      cls_c.lead_due = 2'd3;
      cls_c.lead_win = u8v_pkg::WIN_90_BF;
    end else if (data_byte_i inside {[u8v_pkg::LeadF1 : u8v_pkg::LeadF3]}) begin
      cls_c.lead_due = 2'd3;
    end else if (data_byte_i == u8v_pkg::LeadF4) begin
      // caps at U+10FFFF
      cls_c.lead_due = 2'd3;
      cls_c.lead_win = u8v_pkg::WIN_80_8F;
    end else begin
      cls_c.lead_bad = 1'b1;
    end
  end

  assign in_ready_o = !vld_q || cls_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (cls_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cls_q <= cls_c;
    end
  end

  assign cls_valid_o = vld_q;
  assign cls_o       = cls_q;

endmodule

@@ src/u8v_fifo.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream validator queue
// Short FIFO of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
module u8v_fifo #(
  parameter int unsigned Depth = u8v_pkg::FifoDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  u8v_pkg::class_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output u8v_pkg::class_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  u8v_pkg::class_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = cnt_q != FullCnt;
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ src/u8v_back.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream validator back end
// Sequence state update per byte and registered verdict output.
// ----------------------------------------------------------------------------
`include "utf8_stream_validator_defines.svh"

module u8v_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cls_valid_i,
  output logic            cls_ready_o,
  input  u8v_pkg::class_t cls_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            fault_seen_o,
  output logic            verdict_ready_o,
  output logic            string_valid_o
);

  logic          [1:0] due_q, due_d;
  u8v_pkg::win_e       win_q, win_d;
  logic                pend_q, pend_d;
  logic                fault_q, fault_d;

  logic out_vld_q, out_vld_d;
  logic out_fault_q, out_fault_d;
  logic out_verdict_q, out_verdict_d;
  logic out_okay_q, out_okay_d;

  u8v_pkg::win_e win_sel;
  logic          cont_ok;
  logic          pop;
  logic [1:0]    due_n;
  logic          fault_n;

  assign cls_ready_o = !out_vld_q || out_ready_i;
  assign pop         = cls_valid_i && cls_ready_o;

  always_comb begin
    win_sel = pend_q ? win_q : u8v_pkg::WIN_ANY;
    case (win_sel)
      u8v_pkg::WIN_A0_BF: cont_ok = cls_i.cont_ok[u8v_pkg::WIN_A0_BF];
      u8v_pkg::WIN_80_9F: cont_ok = cls_i.cont_ok[u8v_pkg::WIN_80_9F];
      u8v_pkg::WIN_90_BF: cont_ok = cls_i.cont_ok[u8v_pkg::WIN_90_BF];
      u8v_pkg::WIN_80_8F: cont_ok = cls_i.cont_ok[u8v_pkg::WIN_80_8F];
      default:            cont_ok = cls_i.cont_ok[u8v_pkg::WIN_ANY];
    endcase
  end

  always_comb begin
    due_d   = due_q;
    win_d   = win_q;
    pend_d  = pend_q;
    fault_d = fault_q;

    out_vld_d     = out_vld_q;
    out_fault_d   = out_fault_q;
    out_verdict_d = out_verdict_q;
    out_okay_d    = out_okay_q;

    // sequence step for the head byte
    due_n   = due_q;
    fault_n = fault_q;
    if (due_q != 2'd0) begin
      // bad continuation closes the sequence; the byte is not re-read as a lead
      due_n  = cont_ok ? due_q - 2'd1 : 2'd0;
      fault_n = fault_q | !cont_ok;
    end else if (cls_i.lead_bad) begin
      fault_n = 1'b1;
    end else begin
      due_n = cls_i.lead_due;
    end

    if (pop) begin
      out_vld_d = 1'b1;
      if (cls_i.last) begin
        out_fault_d   = fault_n | (due_n != 2'd0);
        out_verdict_d = 1'b1;
        out_okay_d    = !(fault_n | (due_n != 2'd0));
        due_d         = 2'd0;
        win_d         = u8v_pkg::WIN_ANY;
        pend_d        = 1'b0;
        fault_d       = 1'b0;
      end else begin
        out_fault_d   = fault_n;
        out_verdict_d = 1'b0;
        out_okay_d    = 1'b0;
        due_d         = due_n;
        fault_d       = fault_n;
        if (due_q == 2'd0 && !cls_i.lead_bad && cls_i.lead_due != 2'd0) begin
          win_d  = cls_i.lead_win;
          pend_d = 1'b1;
        end else begin
          win_d  = u8v_pkg::WIN_ANY;
          pend_d = 1'b0;
        end
      end
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_q     <= 2'd0;
      win_q     <= u8v_pkg::WIN_ANY;
      pend_q    <= 1'b0;
      fault_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      due_q     <= due_d;
      win_q     <= win_d;
      pend_q    <= pend_d;
      fault_q   <= fault_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_fault_q   <= out_fault_d;
    out_verdict_q <= out_verdict_d;
    out_okay_q    <= out_okay_d;
  end

  assign out_valid_o     = out_vld_q;
  assign fault_seen_o    = out_fault_q;
  assign verdict_ready_o = out_verdict_q;
  assign string_valid_o  = out_okay_q;

  `U8V_ASSERT_IMP(a_pend_has_due, pend_q, due_q != 2'd0, "first continuation pending while idle")
  `U8V_ASSERT_IMP(a_win_needs_pend, win_q != u8v_pkg::WIN_ANY, pend_q, "stale narrow window")
  `U8V_ASSERT_NXT(a_last_clears, pop && cls_i.last,
                  due_q == 2'd0 && !pend_q && !fault_q, "state kept across strings")
  `U8V_ASSERT_IMP(a_valid_verdict, out_vld_q && out_okay_q,
                  out_verdict_q && !out_fault_q, "valid verdict with fault or mid-string")

endmodule

@@ src/utf8_stream_validator.sv @@
// Each byte passes the front register, the queue and the output register on the way to its result.
// Throughput: one byte per cycle while the output accepts; the back end updates the sequence state per byte.
// Back-pressure on the output stalls the back end; the front keeps filling the queue.
// Reset (rst_ni low, asynchronous) empties all stages and returns sequence state to idle.
// ----------------------------------------------------------------------------
// UTF-8 stream validator
// Strict RFC 3629 well-formedness check, one byte and one result per transfer.
// ----------------------------------------------------------------------------
module utf8_stream_validator #(
  parameter int unsigned FifoDepth = u8v_pkg::FifoDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  u8v_in_if.sink    in_i,
  u8v_out_if.source out_o
);

  logic            f_valid, f_ready;
  u8v_pkg::class_t f_cls;
  logic            q_valid, q_ready;
  u8v_pkg::class_t q_cls;

  u8v_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_i.valid),
    .in_ready_o      (in_i.ready),
    .data_byte_i     (in_i.data_byte),
    .end_of_string_i (in_i.end_of_string),
    .cls_valid_o     (f_valid),
    .cls_ready_i     (f_ready),
    .cls_o           (f_cls)
  );

  u8v_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_cls),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_cls)
  );

  u8v_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cls_valid_i     (q_valid),
    .cls_ready_o     (q_ready),
    .cls_i           (q_cls),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .fault_seen_o    (out_o.fault_seen),
    .verdict_ready_o (out_o.verdict_ready),
    .string_valid_o  (out_o.string_valid)
  );

endmodule

@@ dv/utf8_stream_validator_tb.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream validator testbench
// Feeds byte strings through the valid/ready input and checks every result.
// Strings are mostly well-formed, some corrupted, truncated or plain noise.
// A local predictor tracks the sequence state and queues the expected
// verdicts. Both sides stall in random bursts.
// ----------------------------------------------------------------------------
module utf8_stream_validator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned HoldCycles = 400;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic fault;
    logic verdict;
    logic ok;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  u8v_in_if  in_if ();
  u8v_out_if out_if ();

  utf8_stream_validator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  byte_item_t  pending_q [$];
  verdict_t    verdict_q [$];
  logic [7:0]  str_q [$];
  byte_item_t  tx_next;

  // predictor state
  logic [1:0]     seq_left;
  u8v_pkg::win_e  seq_win;
  logic           seq_first;
  logic           seq_fault;

  bit          idle_en = 1'b1;
  bit          rx_hold_req = 1'b0;
  bit          rx_hold_ack;
  int unsigned rx_hold_cnt;
  int unsigned tx_gap, tx_run, rx_gap, rx_run;
  int unsigned cyc = 0;
  int unsigned err_cnt = 0;
  int unsigned planned = 0;
  int unsigned results_seen = 0;
  int unsigned str_total = 0, str_good = 0, str_bad = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic flag_error(input string msg);
    err_cnt++;
    $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  function automatic logic cont_fits(input logic [7:0] b, input u8v_pkg::win_e w);
    case (w)
      u8v_pkg::WIN_A0_BF: return b >= u8v_pkg::ByteA0 && b <= u8v_pkg::ByteBF;
      u8v_pkg::WIN_80_9F: return b >= u8v_pkg::ContTag && b <= u8v_pkg::Byte9F;
      u8v_pkg::WIN_90_BF: return b >= u8v_pkg::Byte90 && b <= u8v_pkg::ByteBF;
      u8v_pkg::WIN_80_8F: return b >= u8v_pkg::ContTag && b <= u8v_pkg::Byte8F;
      default:            return (b & u8v_pkg::ContMask) == u8v_pkg::ContTag;
    endcase
  endfunction

  // advance the sequence state by one byte and queue the result it gives
  task automatic predict_byte(input logic [7:0] b, input logic last);
    verdict_t      v;
    logic [1:0]    due;
    u8v_pkg::win_e w;
    due = 2'd0;
    w   = u8v_pkg::WIN_ANY;
    if (seq_left != 2'd0) begin
      w = seq_first ? seq_win : u8v_pkg::WIN_ANY;
      if (cont_fits(b, w)) begin
        seq_left = seq_left - 2'd1;
      end else begin
        // bad continuation closes the sequence; byte is not re-read as a lead
        seq_fault = 1'b1;
        seq_left  = 2'd0;
      end
      seq_first = 1'b0;
      seq_win   = u8v_pkg::WIN_ANY;
    end else if (b >= u8v_pkg::ContTag) begin
      if (b >= u8v_pkg::Lead2Lo && b <= u8v_pkg::Lead2Hi) begin
        due = 2'd1; w = u8v_pkg::WIN_ANY;
      end else if (b == u8v_pkg::LeadE0) begin
        due = 2'd2; w = u8v_pkg::WIN_A0_BF;
      end else if (b == u8v_pkg::LeadED) begin
        due = 2'd2; w = u8v_pkg::WIN_80_9F;
      end else if (b >= u8v_pkg::LeadE1 && b <= u8v_pkg::LeadEF) begin
        due = 2'd2; w = u8v_pkg::WIN_ANY;
      end else if (b == u8v_pkg::LeadF0) begin
        due = 2'd3; w = u8v_pkg::WIN_90_BF;
      end else if (b >= u8v_pkg::LeadF1 && b <= u8v_pkg::LeadF3) begin
        due = 2'd3; w = u8v_pkg::WIN_ANY;
      end else if (b == u8v_pkg::LeadF4) begin
        due = 2'd3; w = u8v_pkg::WIN_80_8F;
      end else begin
        seq_fault = 1'b1;
      end
      if (due != 2'd0) begin
        seq_left  = due;
        seq_win   = w;
        seq_first = 1'b1;
      end
    end
    if (last) begin
      v.fault   = seq_fault | (seq_left != 2'd0);
      v.verdict = 1'b1;
      v.ok      = ~v.fault;
      str_total++;
      if (v.ok) str_good++;
      else str_bad++;
      seq_left  = 2'd0;
      seq_win   = u8v_pkg::WIN_ANY;
      seq_first = 1'b0;
      seq_fault = 1'b0;
    end else begin
      v.fault   = seq_fault;
      v.verdict = 1'b0;
      v.ok      = 1'b0;
    end
    verdict_q.push_back(v);
  endtask

  task automatic check_result();
    verdict_t want;
    if (verdict_q.size() == 0) begin
      flag_error("result transfer with nothing expected");
      return;
    end
    want = verdict_q.pop_front();
    results_seen++;
    if (out_if.fault_seen !== want.fault)
      flag_error($sformatf("result %0d: fault_seen %b, expected %b",
                           results_seen, out_if.fault_seen, want.fault));
    if (out_if.verdict_ready !== want.verdict)
      flag_error($sformatf("result %0d: verdict_ready %b, expected %b",
                           results_seen, out_if.verdict_ready, want.verdict));
    if (out_if.string_valid !== want.ok)
      flag_error($sformatf("result %0d: string_valid %b, expected %b",
                           results_seen, out_if.string_valid, want.ok));
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid         <= 1'b0;
      in_if.data_byte     <= '0;
      in_if.end_of_string <= 1'b0;
      tx_gap              <= 0;
      tx_run              <= 0;
    end else begin
      if (in_if.valid && in_if.ready) predict_byte(in_if.data_byte, in_if.end_of_string);
      if (!in_if.valid || in_if.ready) begin
        if (tx_gap != 0) begin
          in_if.valid <= 1'b0;
          tx_gap      <= tx_gap - 1;
        end else if (pending_q.size() != 0) begin
          tx_next              = pending_q.pop_front();
          in_if.valid         <= 1'b1;
          in_if.data_byte     <= tx_next.data_byte;
          in_if.end_of_string <= tx_next.last;
          if (idle_en && tx_run == 0 && $urandom_range(0, 3) == 0) begin
            tx_gap <= $urandom_range(1, 16);
            tx_run <= $urandom_range(0, 40);
          end else if (tx_run != 0) begin
            tx_run <= tx_run - 1;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold, started by a toggle of rx_hold_req
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_hold_cnt <= 0;
      rx_hold_ack <= 1'b0;
    end else if (rx_hold_req != rx_hold_ack) begin
      rx_hold_cnt <= HoldCycles;
      rx_hold_ack <= rx_hold_req;
    end else if (rx_hold_cnt != 0) begin
      rx_hold_cnt <= rx_hold_cnt - 1;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_gap       <= 0;
      rx_run       <= 0;
    end else begin
      if (out_if.valid && out_if.ready) check_result();
      if (rx_hold_cnt != 0) begin
        out_if.ready <= 1'b0;
      end else if (rx_gap != 0) begin
        out_if.ready <= 1'b0;
        rx_gap       <= rx_gap - 1;
      end else if (idle_en && rx_run == 0 && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        rx_gap       <= $urandom_range(0, 15);
        rx_run       <= $urandom_range(0, 48);
      end else begin
        out_if.ready <= 1'b1;
        if (rx_run != 0) rx_run <= rx_run - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cyc, verdict_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // move the assembled string into the pending queue, end mark on its last byte
  task automatic send_str();
    byte_item_t it;
    if (str_q.size() == 0) str_q.push_back(8'h00);
    foreach (str_q[i]) begin
      it.data_byte = str_q[i];
      it.last      = (i == str_q.size() - 1);
      pending_q.push_back(it);
      planned++;
    end
    str_q.delete();
  endtask

  // biased towards the ends of the range
  function automatic logic [7:0] pick_in(input logic [7:0] lo, input logic [7:0] hi);
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      default: return 8'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic add_tail(input int unsigned n, input u8v_pkg::win_e w);
    logic [7:0] lo, hi;
    case (w)
      u8v_pkg::WIN_A0_BF: begin lo = u8v_pkg::ByteA0;  hi = u8v_pkg::ByteBF; end
      u8v_pkg::WIN_80_9F: begin lo = u8v_pkg::ContTag; hi = u8v_pkg::Byte9F; end
      u8v_pkg::WIN_90_BF: begin lo = u8v_pkg::Byte90;  hi = u8v_pkg::ByteBF; end
      u8v_pkg::WIN_80_8F: begin lo = u8v_pkg::ContTag; hi = u8v_pkg::Byte8F; end
      default:            begin lo = u8v_pkg::ContTag; hi = u8v_pkg::ByteBF; end
    endcase
    str_q.push_back(pick_in(lo, hi));
    repeat (n - 1) str_q.push_back(pick_in(u8v_pkg::ContTag, u8v_pkg::ByteBF));
  endtask

  // one well-formed character
  task automatic add_char();
    int unsigned kind;
    logic [7:0]  lead;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      str_q.push_back(pick_in(8'h00, 8'h7F));
    end else if (kind < 5) begin
      str_q.push_back(pick_in(u8v_pkg::Lead2Lo, u8v_pkg::Lead2Hi));
      add_tail(1, u8v_pkg::WIN_ANY);
    end else if (kind < 8) begin
      lead = pick_in(u8v_pkg::LeadE0, u8v_pkg::LeadEF);
      if ($urandom_range(0, 3) == 0) lead = u8v_pkg::LeadED;
      str_q.push_back(lead);
      add_tail(2, lead == u8v_pkg::LeadE0 ? u8v_pkg::WIN_A0_BF :
                  lead == u8v_pkg::LeadED ? u8v_pkg::WIN_80_9F : u8v_pkg::WIN_ANY);
    end else begin
      lead = pick_in(u8v_pkg::LeadF0, u8v_pkg::LeadF4);
      str_q.push_back(lead);
      add_tail(3, lead == u8v_pkg::LeadF0 ? u8v_pkg::WIN_90_BF :
                  lead == u8v_pkg::LeadF4 ? u8v_pkg::WIN_80_8F : u8v_pkg::WIN_ANY);
    end
  endtask

  task automatic random_string();
    int unsigned mode, n;
    mode = $urandom_range(0, 9);
    n    = $urandom_range(1, 10);
    if (mode == 0) begin
      repeat (n) str_q.push_back(8'($urandom));
    end else if (mode == 1) begin
      // leads with narrow windows or bad leads, followed by bytes at window edges
      repeat ((n + 2) / 3) begin
        case ($urandom_range(0, 6))
          0:       str_q.push_back(u8v_pkg::LeadE0);
          1:       str_q.push_back(u8v_pkg::LeadED);
          2:       str_q.push_back(u8v_pkg::LeadF0);
          3:       str_q.push_back(u8v_pkg::LeadF4);
          4:       str_q.push_back(8'hC1);
          5:       str_q.push_back(8'hF5);
          default: str_q.push_back(8'($urandom));
        endcase
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 6))
            0:       str_q.push_back(u8v_pkg::Byte8F);
            1:       str_q.push_back(u8v_pkg::Byte90);
            2:       str_q.push_back(u8v_pkg::Byte9F);
            3:       str_q.push_back(u8v_pkg::ByteA0);
            4:       str_q.push_back(u8v_pkg::ContTag);
            5:       str_q.push_back(u8v_pkg::ByteBF);
            default: str_q.push_back(8'($urandom));
          endcase
        end
      end
    end else begin
      repeat (n) add_char();
      if ($urandom_range(0, 5) == 0)
        str_q[$urandom_range(0, str_q.size() - 1)] = 8'($urandom);
      // cut the last character short
      if ($urandom_range(0, 7) == 0) begin
        add_char();
        void'(str_q.pop_back());
      end
    end
    send_str();
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_if.valid || verdict_q.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    in_if.valid         = 1'b0;
    in_if.data_byte     = '0;
    in_if.end_of_string = 1'b0;
    out_if.ready        = 1'b0;
    seq_left  = 2'd0;
    seq_win   = u8v_pkg::WIN_ANY;
    seq_first = 1'b0;
    seq_fault = 1'b0;
    rst_ni    = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero byte, bad leads, stray continuation, overlong, surrogate,
    // above U+10FFFF, truncation, the largest and smallest well-formed forms
    str_q = '{8'h00};                      send_str();
    str_q = '{8'h7F};                      send_str();
    str_q = '{8'hFF};                      send_str();
    str_q = '{8'h80};                      send_str();
    str_q = '{8'hC0, 8'h80};               send_str();
    str_q = '{8'hC1};                      send_str();
    str_q = '{8'hE0, 8'h9F, 8'h80};        send_str();
    str_q = '{8'hED, 8'hA0, 8'h80};        send_str();
    str_q = '{8'hF4, 8'h90, 8'h80, 8'h80}; send_str();
    str_q = '{8'hF0, 8'h90, 8'h80};        send_str();
    str_q = '{8'hF4, 8'h8F, 8'hBF, 8'hBF}; send_str();
    str_q = '{8'hC2, 8'h80};               send_str();
    wait_drained();

    // receiver holds off while strings keep coming; the input backs up
    rx_hold_req = ~rx_hold_req;
    repeat (20) random_string();
    wait_drained();

    while (planned < 1350) random_string();
    while (pending_q.size() != 0) @(negedge clk_i);

    // last stretch at full rate
    idle_en = 1'b0;
    while (planned < 1600) random_string();
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (verdict_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", verdict_q.size()));
    $display("%0d bytes in %0d strings checked: %0d accepted, %0d rejected",
             results_seen, str_total, str_good, str_bad);
    $display("covered bad leads, bad and missing continuations, full-rate and held-off output");
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
